@@ design/buzzer_tone_pattern_sequencer_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Buzzer tone pattern sequencer: assertion macros
// Shorthand for the concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BUZZER_TONE_PATTERN_SEQUENCER_UNIT_ASSERT_SVH
`define BUZZER_TONE_PATTERN_SEQUENCER_UNIT_ASSERT_SVH

// Condition in the same cycle implies a consequence in the same cycle.
`define BTPS_ASSERT_SAME(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Condition in one cycle implies a consequence in the following cycle.
`define BTPS_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

@@ design/btps_pkg.sv @@
// ----------------------------------------------------------------------------
// Buzzer tone pattern sequencer package
// Payload types, request and tune codes, register indexes and tone tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btps_pkg;

   // Default width of the millisecond time base.
   localparam int TIME_BITS_DEFAULT = 32;

   // Duty resolution of the passive drive and the half-duty level.
   localparam int DUTY_BITS = 10;
   localparam logic [DUTY_BITS-1:0] HALF_DUTY = DUTY_BITS'((1 << DUTY_BITS) / 2);

   // Result buffer depth (a power of two, so the pointers wrap naturally).
   localparam int OUT_DEPTH = 2;

   // Register index width on the configuration port.
   localparam int CSR_INDEX_BITS = 2;

   // Request codes.
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_PLAY = 2'd1;
   localparam logic [1:0] REQ_STOP = 2'd2;

   // Tune codes.
   localparam logic [2:0] TUNE_NONE    = 3'd0;
   localparam logic [2:0] TUNE_WORKING = 3'd1;
   localparam logic [2:0] TUNE_DONE    = 3'd2;
   localparam logic [2:0] TUNE_REFUSED = 3'd3;
   localparam logic [2:0] TUNE_TEST    = 3'd4;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLED      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PASSIVE_MODE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_LOW   = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [2:0]  tune_sel;
      logic [31:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic                 tone_on;
      logic [15:0]          tone_hz;
      logic [DUTY_BITS-1:0] pwm_duty;
      logic                 pin_level;
      logic [2:0]           playing_tune;
      logic [2:0]           step_index;
   } rsp_payload_type;

   typedef struct packed {
      logic                      valid;
      logic [CSR_INDEX_BITS-1:0] index;
      logic                      data;
   } csr_write_type;

   // Tone frequency of one step of a tune; zero means silence.
   function automatic logic [15:0] step_hz(input logic [2:0] tune, input logic [2:0] step);
      logic [15:0] hz;
      hz = 16'd0;
      case (tune)
         TUNE_WORKING: hz = (step == 3'd0) ? 16'd2200 : 16'd0;
         TUNE_DONE: begin
            case (step)
               3'd0:    hz = 16'd1568;
               3'd2:    hz = 16'd2349;
               default: hz = 16'd0;
            endcase
         end
         TUNE_REFUSED: hz = 16'd440;
         TUNE_TEST: hz = step[0] ? 16'd0 : 16'd2000;
         default: hz = 16'd0;
      endcase
      return hz;
   endfunction

   // Duration of one step of a tune in milliseconds.
   function automatic logic [9:0] step_ms(input logic [2:0] tune, input logic [2:0] step);
      logic [9:0] ms;
      ms = 10'd0;
      case (tune)
         TUNE_WORKING: ms = (step == 3'd0) ? 10'd120 : 10'd880;
         TUNE_DONE: begin
            case (step)
               3'd0:    ms = 10'd160;
               3'd1:    ms = 10'd60;
               default: ms = 10'd280;
            endcase
         end
         TUNE_REFUSED: ms = 10'd500;
         TUNE_TEST: ms = 10'd150;
         default: ms = 10'd0;
      endcase
      return ms;
   endfunction

   // Number of steps in a tune.
   function automatic logic [2:0] tune_len(input logic [2:0] tune);
      logic [2:0] len;
      len = 3'd1;
      case (tune)
         TUNE_WORKING: len = 3'd2;
         TUNE_DONE:    len = 3'd3;
         TUNE_REFUSED: len = 3'd1;
         TUNE_TEST:    len = 3'd5;
         default:      len = 3'd1;
      endcase
      return len;
   endfunction

endpackage

@@ design/btps_core.sv @@
// ----------------------------------------------------------------------------
// Buzzer tone pattern sequencer core
// Holds the configuration and the tune state, applies one request per cycle
// and forms the drive result from the state the request leaves behind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btps_core
   import btps_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  csr_write_type   csr_write,
   input  logic            item_valid,
   input  req_payload_type item,
   output rsp_payload_type result
);

   logic [2:0]           tune_ff, tune_in;
   logic [2:0]           step_ff, step_in;
   logic [TIME_BITS-1:0] deadline_ff, deadline_in;
   logic [15:0]          hz_ff, hz_in;
   logic                 enabled_ff, enabled_in;
   logic                 passive_ff, passive_in;
   logic                 active_low_ff, active_low_in;

   logic [TIME_BITS+31:0] now_wide;
   logic [TIME_BITS-1:0]  now_t;
   logic [TIME_BITS-1:0]  diff;
   logic [2:0]            step_next;
   logic                  tune_valid;
   logic                  do_enter;
   logic                  do_halt;
   logic [2:0]            enter_tune;
   logic [2:0]            enter_step;
   logic                  sounding;

   // The millisecond count reduced or extended to the time base width.
   assign now_wide  = {{TIME_BITS{1'b0}}, item.now_ms};
   assign now_t     = now_wide[TIME_BITS-1:0];
   assign diff      = now_t - deadline_ff;
   assign step_next = step_ff + 3'd1;
   assign tune_valid = (tune_ff == TUNE_WORKING) || (tune_ff == TUNE_DONE) ||
                       (tune_ff == TUNE_REFUSED) || (tune_ff == TUNE_TEST);

   // Next state: a write to a defined register reconfigures and stops the tune;
   // with no write, the request decides whether a step is entered or the tune halts.
   always_comb begin
      tune_in       = tune_ff;
      step_in       = step_ff;
      deadline_in   = deadline_ff;
      hz_in         = hz_ff;
      enabled_in    = enabled_ff;
      passive_in    = passive_ff;
      active_low_in = active_low_ff;
      do_enter      = 1'b0;
      do_halt       = 1'b0;
      enter_tune    = tune_ff;
      enter_step    = 3'd0;

      if (csr_write.valid) begin
         case (csr_write.index)
            CSR_ENABLED: begin
               enabled_in = csr_write.data;
               do_halt    = 1'b1;
            end
            CSR_PASSIVE_MODE: begin
               passive_in = csr_write.data;
               do_halt    = 1'b1;
            end
            CSR_ACTIVE_LOW: begin
               active_low_in = csr_write.data;
               do_halt       = 1'b1;
            end
            default: ;
         endcase
      end else if (item_valid) begin
         case (item.req_type)
            REQ_PLAY: begin
               if (!enabled_ff) begin
                  tune_in = TUNE_NONE;
               end else if ((item.tune_sel >= TUNE_WORKING) &&
                            (item.tune_sel <= TUNE_TEST)) begin
                  tune_in    = item.tune_sel;
                  enter_tune = item.tune_sel;
                  do_enter   = 1'b1;
               end else begin
                  do_halt = 1'b1;
               end
            end
            REQ_STOP: do_halt = 1'b1;
            REQ_TICK: begin
               // The step is over once the wrapped difference is not negative.
               if (tune_valid && enabled_ff && !diff[TIME_BITS-1]) begin
                  if (step_next < tune_len(tune_ff)) begin
                     enter_step = step_next;
                     do_enter   = 1'b1;
                  end else if (tune_ff == TUNE_WORKING) begin
                     do_enter = 1'b1;
                  end else begin
                     do_halt = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      if (do_enter) begin
         step_in     = enter_step;
         hz_in       = step_hz(enter_tune, enter_step);
         deadline_in = now_t + TIME_BITS'(step_ms(enter_tune, enter_step));
      end
      if (do_halt) begin
         tune_in = TUNE_NONE;
         step_in = 3'd0;
         hz_in   = 16'd0;
      end
   end

   // State and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tune_ff       <= TUNE_NONE;
         step_ff       <= 3'd0;
         deadline_ff   <= '0;
         hz_ff         <= 16'd0;
         enabled_ff    <= 1'b0;
         passive_ff    <= 1'b0;
         active_low_ff <= 1'b0;
      end else begin
         tune_ff       <= tune_in;
         step_ff       <= step_in;
         deadline_ff   <= deadline_in;
         hz_ff         <= hz_in;
         enabled_ff    <= enabled_in;
         passive_ff    <= passive_in;
         active_low_ff <= active_low_in;
      end
   end

   // Drive result from the state after the request.
   assign sounding = enabled_in && (hz_in != 16'd0);

   always_comb begin
      result.tone_on      = sounding;
      result.tone_hz      = (sounding && passive_in) ? hz_in : 16'd0;
      result.pwm_duty     = (sounding && passive_in) ? HALF_DUTY : '0;
      result.pin_level    = (enabled_in && !passive_in) ? (sounding ^ active_low_in) : 1'b0;
      result.playing_tune = tune_in;
      result.step_index   = step_in;
   end

endmodule

@@ design/btps_out_buffer.sv @@
// ----------------------------------------------------------------------------
// Buzzer tone pattern sequencer result buffer
// Small queue of result registers between the core and the result channel,
// so that a stalled result does not hold up the next request at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btps_out_buffer
   import btps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  rsp_payload_type in_payload,
   output logic            full,
   output logic            out_valid,
   input  logic            out_stall,
   output rsp_payload_type out_payload
);

   localparam int PTR_BITS = $clog2(OUT_DEPTH);
   localparam int CNT_BITS = $clog2(OUT_DEPTH + 1);

   rsp_payload_type       entry_ff [OUT_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign full        = (count_ff == CNT_BITS'(OUT_DEPTH));
   assign out_valid   = (count_ff != '0);
   assign out_payload = entry_ff[rd_ptr_ff];
   assign push        = in_valid && !full;
   assign pop         = out_valid && !out_stall;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage; only the pointers and the fill count need a reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_payload;
      end
   end

endmodule

@@ design/buzzer_tone_pattern_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// Buzzer tone pattern sequencer unit
// Top level: configuration port, sequencer core and result buffer.
// ----------------------------------------------------------------------------
// Every request (tick, play or stop) yields exactly one result, which appears
// on the result channel in the cycle after the request transfer at the earliest.
// A request can be taken in every cycle in which req_stall is low: the core
// applies it to the tune state, and a two-entry result buffer holds results while
// the result channel stalls; req_stall rises only when both entries are occupied.
// The configuration port is always ready; a write to a defined register also
// stops the playing tune, and writes are expected only while the unit is idle.
`timescale 1ns / 1ps

module buzzer_tone_pattern_sequencer_unit
   import btps_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic                      csr_wdata
);

   csr_write_type   csr_write;
   rsp_payload_type core_result;
   logic            buf_full;
   logic            req_transfer;

   // Configuration writes are taken in any cycle.
   assign csr_ready       = 1'b1;
   assign csr_write.valid = csr_valid && csr_ready;
   assign csr_write.index = csr_index;
   assign csr_write.data  = csr_wdata;

   assign req_stall    = buf_full;
   assign req_transfer = req_valid && !req_stall;

   btps_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .item_valid (req_transfer),
      .item       (req_payload),
      .result     (core_result)
   );

   btps_out_buffer u_out_buffer (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_transfer),
      .in_payload  (core_result),
      .full        (buf_full),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_payload (rsp_payload)
   );

endmodule

@@ design/btps_checker.sv @@
// ----------------------------------------------------------------------------
// Buzzer tone pattern sequencer port checker
// Watches the top-level ports for result ordering and back-pressure slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "buzzer_tone_pattern_sequencer_unit_assert.svh"

module btps_checker
   import btps_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input req_payload_type           req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input rsp_payload_type           rsp_payload
);

   logic req_transfer;
   logic stop_on_empty;

   assign req_transfer  = req_valid && !req_stall;
   assign stop_on_empty = req_transfer && !rsp_valid && (req_payload.req_type == REQ_STOP);

   // A result that is held back stays unchanged.
   `BTPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")

   // Every request transfer leaves a result waiting in the next cycle.
   `BTPS_ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_transfer, rsp_valid, "request transfer gave no result")

   // Requests are held back only while results are waiting.
   `BTPS_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid, "request stalled with no result waiting")

   // A stop seen on an empty result channel comes back silent and with no tune.
   `BTPS_ASSERT_NEXT(a_stop_silent, clock, reset, stop_on_empty, rsp_valid && !rsp_payload.tone_on && (rsp_payload.playing_tune == TUNE_NONE), "stop result not silent")

endmodule

bind buzzer_tone_pattern_sequencer_unit btps_checker u_checker (.*);
